FILE: hdl/dfmr_pkg.sv
// Shared types and constants for the dragonfly minimal route block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dfmr_pkg;

    // Network shape (fixed for this build; divisors are powers of two)
    localparam int NODES_PER_ROUTER        = 4;
    localparam int ROUTERS_PER_GROUP       = 8;
    localparam int GLOBAL_LINKS_PER_ROUTER = 4;
    localparam int LOCAL_PORT_BASE         = 4;
    localparam int GLOBAL_PORT_BASE        = 11;
    localparam int NUM_GROUPS = ROUTERS_PER_GROUP * GLOBAL_LINKS_PER_ROUTER + 1;

    // Field widths
    localparam int DEST_W  = 11;
    localparam int PORT_W  = 4;
    localparam int RTR_W   = 3;
    localparam int GRP_W   = 6;
    localparam int CFG_W   = 6;
    localparam int CIDX_W  = 2;

    // Derived widths
    localparam int NODE_W = $clog2(NODES_PER_ROUTER);
    localparam int RSEL_W = $clog2(ROUTERS_PER_GROUP);
    localparam int LINK_W = $clog2(GLOBAL_LINKS_PER_ROUTER);
    localparam int GQ_W   = DEST_W - NODE_W - RSEL_W;
    localparam int OFF_W  = $clog2(NUM_GROUPS - 1);
    localparam int SUM_W  = PORT_W + 2;
    localparam int MAX_PORT = GLOBAL_PORT_BASE + GLOBAL_LINKS_PER_ROUTER - 1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ROUTER_IN_GROUP = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GROUP_INDEX     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PALM_TREE_MODE  = 2'd2;

    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [PORT_W-1:0] next_in_port;
    } route_t;

    // Local link number toward router target, as seen from router own
    function automatic logic [PORT_W-1:0] local_port(input logic [RSEL_W-1:0] target,
                                                     input logic [RSEL_W-1:0] own);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(LOCAL_PORT_BASE) + SUM_W'(target) - ((target > own) ? SUM_W'(1) : '0);
        return sum[PORT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dfmr_route.sv
// Combinational minimal route computation for one destination node.
// Depends on dfmr_pkg.
`default_nettype none

module dfmr_route import dfmr_pkg::*; (
    input  wire logic [DEST_W-1:0] dest_node,
    input  wire logic [RTR_W-1:0]  router_in_group,
    input  wire logic [GRP_W-1:0]  group_index,
    input  wire logic              palm_tree_mode,
    output route_t                 route
);

    localparam logic [GQ_W:0] G_EXT = (GQ_W + 1)'(NUM_GROUPS);

    logic [NODE_W-1:0]  dp;
    logic [RSEL_W-1:0]  da;
    logic [RSEL_W-1:0]  ta;
    logic [GQ_W-1:0]    grp_raw;
    logic [GQ_W:0]      dh;
    logic [GQ_W:0]      th;
    logic [GQ_W:0]      d_fwd;
    logic [GQ_W:0]      off_w;
    logic [GQ_W:0]      offcmp_w;
    logic [OFF_W-1:0]   off;
    logic [OFF_W-1:0]   offcmp;
    logic [RSEL_W-1:0]  na;
    logic [SUM_W-1:0]   gport;
    logic [SUM_W-1:0]   giport;

    always_comb begin
        dp      = dest_node[NODE_W-1:0];
        da      = dest_node[NODE_W +: RSEL_W];
        grp_raw = dest_node[DEST_W-1 -: GQ_W];
        ta      = RSEL_W'(router_in_group);

        // Wrap group indexes into range; raw values stay below twice the group count
        dh = ({1'b0, grp_raw} >= G_EXT) ? {1'b0, grp_raw} - G_EXT : {1'b0, grp_raw};
        th = ((GQ_W + 1)'(group_index) >= G_EXT) ? (GQ_W + 1)'(group_index) - G_EXT
                                                : (GQ_W + 1)'(group_index);

        // Forward distance from destination group to own group, modulo group count
        d_fwd = (th >= dh) ? th - dh : th + G_EXT - dh;

        if (palm_tree_mode) begin
            off_w    = d_fwd - 1'b1;
            offcmp_w = G_EXT - 1'b1 - d_fwd;
        end else if (dh > th) begin
            off_w    = dh - 1'b1;
            offcmp_w = th;
        end else begin
            off_w    = dh;
            offcmp_w = th - 1'b1;
        end
        off    = off_w[OFF_W-1:0];
        offcmp = offcmp_w[OFF_W-1:0];

        na     = RSEL_W'(off >> LINK_W);
        gport  = SUM_W'(GLOBAL_PORT_BASE) + SUM_W'(off[LINK_W-1:0]);
        giport = SUM_W'(GLOBAL_PORT_BASE) + SUM_W'(offcmp[LINK_W-1:0]);

        priority if (dh != th) begin
            if (na != ta) begin
                route.out_port     = local_port(na, ta);
                route.next_in_port = local_port(ta, na);
            end else begin
                route.out_port     = gport[PORT_W-1:0];
                route.next_in_port = giport[PORT_W-1:0];
            end
        end else if (da != ta) begin
            route.out_port     = local_port(da, ta);
            route.next_in_port = local_port(ta, da);
        end else begin
            route.out_port     = PORT_W'(dp);
            route.next_in_port = '0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dragonfly_min_route_ports_core.sv
// Top level of the dragonfly minimal route block: input register, route logic,
// result register and configuration registers. Depends on dfmr_pkg, dfmr_route.
//
//   channel  | direction | ports                              | handshake
//   ---------+-----------+------------------------------------+-----------------
//   input    | in        | s_dest_node                        | s_valid/s_ready
//   result   | out       | m_out_port, m_next_in_port         | m_valid/m_ready
//   config   | in        | cfg_index, cfg_wdata               | cfg_we, no wait
//
// The input register feeds the result register; one item per cycle sustained while
// m_ready stays high. The route is one pass of combinational logic between the input
// register and the result register. Reset (aresetn low, synchronous) empties both
// stages and clears the configuration. A stalled result holds; the input register
// takes one more item if it is empty and then drops s_ready.
`default_nettype none

module dragonfly_min_route_ports_core import dfmr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire logic [DEST_W-1:0] s_dest_node,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      logic [PORT_W-1:0] m_out_port,
    output      logic [PORT_W-1:0] m_next_in_port,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    logic              in_valid_reg;
    logic [DEST_W-1:0] dest_reg;
    logic              out_valid_reg;
    route_t            route_reg;
    route_t            route_next;
    logic [RTR_W-1:0]  rig_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic              palm_reg;
    logic              out_free;
    logic              in_free;

    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rig_reg  <= '0;
            grp_reg  <= '0;
            palm_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROUTER_IN_GROUP: rig_reg  <= cfg_wdata[RTR_W-1:0];
                CFG_GROUP_INDEX:     grp_reg  <= cfg_wdata[GRP_W-1:0];
                CFG_PALM_TREE_MODE:  palm_reg <= cfg_wdata[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            dest_reg <= s_dest_node;
        end
        if (out_free && in_valid_reg) begin
            route_reg <= route_next;
        end
    end

    dfmr_route u_route (
        .dest_node       (dest_reg),
        .router_in_group (rig_reg),
        .group_index     (grp_reg),
        .palm_tree_mode  (palm_reg),
        .route           (route_next)
    );

    assign m_valid        = out_valid_reg;
    assign m_out_port     = route_reg.out_port;
    assign m_next_in_port = route_reg.next_in_port;

endmodule

`default_nettype wire

FILE: hdl/dfmr_checker.sv
// Port-level checks for the dragonfly minimal route block, bound to the top level.
// Depends on dfmr_pkg and dragonfly_min_route_ports_core.
`default_nettype none

module dfmr_checker import dfmr_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [PORT_W-1:0] m_out_port,
    input wire logic [PORT_W-1:0] m_next_in_port
);

    // Both stages empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_port <= PORT_W'(MAX_PORT))
        else $error("output port out of range");

    // Delivery here has no next router; forwarding always enters a link port
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_port < PORT_W'(NODES_PER_ROUTER)) |-> m_next_in_port == '0)
        else $error("delivered item carries a next input port");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_port >= PORT_W'(NODES_PER_ROUTER))
            |-> m_next_in_port >= PORT_W'(LOCAL_PORT_BASE))
        else $error("forwarded item enters on a node port");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_port) && $stable(m_next_in_port))
        else $error("stalled result changed");

endmodule

bind dragonfly_min_route_ports_core dfmr_checker u_dfmr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_port     (m_out_port),
    .m_next_in_port (m_next_in_port)
);

`default_nettype wire

FILE: tb/sv/tb_dragonfly_min_route_ports_core.sv
// Testbench for dragonfly_min_route_ports_core: random and directed destinations under
// several router/group/arrangement settings, each route checked against an in-bench model.
// Depends on dfmr_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_dragonfly_min_route_ports_core;
    import dfmr_pkg::*;

    // Index with no register behind it; writes there must have no effect
    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

    class route_checker;
        route_t           pending_routes[$];
        int               errors;
        logic [RTR_W-1:0] own_router;
        logic [GRP_W-1:0] own_group;
        logic             palm_tree;

        function new();
            errors     = 0;
            own_router = '0;
            own_group  = '0;
            palm_tree  = 1'b0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_ROUTER_IN_GROUP: own_router = val[RTR_W-1:0];
                CFG_GROUP_INDEX:     own_group  = val[GRP_W-1:0];
                CFG_PALM_TREE_MODE:  palm_tree  = val[0];
                default: ;
            endcase
        endfunction

        function int link_to(int target, int own);
            return LOCAL_PORT_BASE + target - ((target > own) ? 1 : 0);
        endfunction

        function route_t min_route(logic [DEST_W-1:0] dest);
            int     sw, dp, da, dh, ta, th, off, back_off, gate, oport, iport;
            route_t r;
            sw = int'(dest) / NODES_PER_ROUTER;
            dp = int'(dest) % NODES_PER_ROUTER;
            da = sw % ROUTERS_PER_GROUP;
            dh = (sw / ROUTERS_PER_GROUP) % NUM_GROUPS;
            ta = int'(own_router) % ROUTERS_PER_GROUP;
            th = int'(own_group) % NUM_GROUPS;
            if (dh != th) begin
                if (palm_tree) begin
                    off      = (th + NUM_GROUPS - dh) % NUM_GROUPS - 1;
                    back_off = (dh + NUM_GROUPS - th) % NUM_GROUPS - 1;
                end else if (dh > th) begin
                    off      = dh - 1;
                    back_off = th;
                end else begin
                    off      = dh;
                    back_off = th - 1;
                end
                gate = off / GLOBAL_LINKS_PER_ROUTER;
                if (gate != ta) begin
                    oport = link_to(gate, ta);
                    iport = link_to(ta, gate);
                end else begin
                    oport = off % GLOBAL_LINKS_PER_ROUTER + GLOBAL_PORT_BASE;
                    iport = back_off % GLOBAL_LINKS_PER_ROUTER + GLOBAL_PORT_BASE;
                end
            end else if (da != ta) begin
                oport = link_to(da, ta);
                iport = link_to(ta, da);
            end else begin
                oport = dp;
                iport = 0;
            end
            r.out_port     = oport[PORT_W-1:0];
            r.next_in_port = iport[PORT_W-1:0];
            return r;
        endfunction

        function void note_dest(logic [DEST_W-1:0] dest);
            pending_routes.push_back(min_route(dest));
        endfunction

        function void check_route(logic [PORT_W-1:0] out_port, logic [PORT_W-1:0] next_in_port);
            route_t want;
            if (pending_routes.size() == 0) begin
                $error("unexpected result: out_port %0d next_in_port %0d",
                       out_port, next_in_port);
                errors++;
                return;
            end
            want = pending_routes.pop_front();
            if (out_port !== want.out_port) begin
                $error("out_port: expected %0d, actual %0d", want.out_port, out_port);
                errors++;
            end
            if (next_in_port !== want.next_in_port) begin
                $error("next_in_port: expected %0d, actual %0d",
                       want.next_in_port, next_in_port);
                errors++;
            end
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [DEST_W-1:0] s_dest_node = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [PORT_W-1:0] m_out_port;
    logic [PORT_W-1:0] m_next_in_port;
    logic              cfg_we      = 1'b0;
    logic [CIDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]  cfg_wdata   = '0;

    route_checker board;
    logic         send_burst = 1'b0;
    logic         recv_burst = 1'b0;

    // Directed destinations: extremes, consumption, local hops, global hops, wrapped groups
    int reset_dests[3]  = '{0, 3, 2047};
    int consec_dests[11] = '{0, 2047, 1055, 168, 171, 160, 188, 288, 384, 1024, 1225};
    int palm_dests[7]   = '{128, 192, 928, 171, 160, 1055, 2047};

    // Per-phase settings: raw write data, masked by the block
    int phase_rtr[4]  = '{0, 63, 7, 3};
    int phase_grp[4]  = '{0, 32, 63, 33};
    int phase_palm[4] = '{0, 1, 0, 63};

    dragonfly_min_route_ports_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dest_node    (s_dest_node),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_port     (m_out_port),
        .m_next_in_port (m_next_in_port),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_dest(input logic [DEST_W-1:0] dest);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_dest_node <= dest;
        do @(posedge aclk); while (!s_ready);
        board.note_dest(dest);
    endtask

    task automatic take_results();
        int gap;
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_route(m_out_port, m_next_in_port);
        end
    endtask

    // Hold off input until every outstanding route has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending_routes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_config(input int rtr, input int grp, input int palm);
        write_reg(CFG_ROUTER_IN_GROUP, CFG_W'(rtr));
        write_reg(CFG_GROUP_INDEX, CFG_W'(grp));
        write_reg(CFG_PALM_TREE_MODE, CFG_W'(palm));
        cfg_we <= 1'b0;
    endtask

    // A quarter of the traffic targets this group (or its wrapped alias)
    function automatic logic [DEST_W-1:0] random_dest();
        int g, r, n;
        if ($urandom_range(0, 3) == 0) begin
            g = int'(board.own_group) % NUM_GROUPS;
            if ($urandom_range(0, 1) == 1 && g + NUM_GROUPS < (1 << GQ_W)) g += NUM_GROUPS;
            r = ($urandom_range(0, 1) == 1) ? int'(board.own_router)
                                            : $urandom_range(0, ROUTERS_PER_GROUP - 1);
            n = $urandom_range(0, NODES_PER_ROUTER - 1);
            return DEST_W'((g * ROUTERS_PER_GROUP + r) * NODES_PER_ROUTER + n);
        end
        return DEST_W'($urandom_range(0, (1 << DEST_W) - 1));
    endfunction

    initial begin
        board = new();
        send_burst = 1'($urandom_range(0, 1));
        recv_burst = 1'($urandom_range(0, 1));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            take_results();
        join_none

        foreach (reset_dests[i]) send_dest(DEST_W'(reset_dests[i]));
        settle();
        apply_config(2, 5, 0);
        foreach (consec_dests[i]) send_dest(DEST_W'(consec_dests[i]));
        settle();
        write_reg(CFG_PALM_TREE_MODE, CFG_W'(1));
        write_reg(CFG_SPARE, CFG_W'(63));
        cfg_we <= 1'b0;
        foreach (palm_dests[i]) send_dest(DEST_W'(palm_dests[i]));

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            if (phase < 4)
                apply_config(phase_rtr[phase], phase_grp[phase], phase_palm[phase]);
            else
                apply_config($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63));
            repeat (212) send_dest(random_dest());
        end
        settle();

        if (board.errors == 0) begin
            $display("tb_dragonfly_min_route_ports_core: PASS");
        end else begin
            $display("tb_dragonfly_min_route_ports_core: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_dragonfly_min_route_ports_core: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dfmr_pkg.sv
hdl/dfmr_route.sv
hdl/dragonfly_min_route_ports_core.sv
hdl/dfmr_checker.sv
tb/sv/tb_dragonfly_min_route_ports_core.sv
